// ===== sv/pfav_pkg.sv =====
// Shared types and constants for the polygon face area vector block.
package pfav_pkg;

    localparam int COORD_W      = 24;
    localparam int IN_W         = 24;
    localparam int ACC_W        = 56;
    localparam int SUM_W        = 58;
    localparam int PROD_W       = 2 * IN_W;
    localparam int MAX_VERTICES = 64;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int HALF_W       = ACC_W / 2;
    localparam int SQ_W         = 2 * ACC_W;
    localparam int REM_W        = ACC_W + 2;
    localparam int EDGE_SHIFT   = 13;

    // Dimension register codes
    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;
    localparam logic [1:0] DIM_RESET = DIM_3D;

    typedef logic signed [IN_W-1:0]   t_coord;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;

    // One finished face handed from the front to the back
    typedef struct packed {
        t_acc area_x;
        t_acc area_y;
        t_acc area_z;
        t_acc norm_z;
        logic bad_dim;
        logic sat;
    } t_face;

    // Take the low COORD_W bits of a field as a signed coordinate
    function automatic t_coord coord_of(input logic [IN_W-1:0] raw);
        logic signed [COORD_W-1:0] c;
        c = signed'(raw[COORD_W-1:0]);
        return t_coord'(c);
    endfunction

endpackage

// ===== sv/pfav_front.sv =====
// Front end: takes vertices, accumulates edge cross products, closes faces.
module pfav_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [23:0]          i_vx,
    input  logic [23:0]          i_vy,
    input  logic [23:0]          i_vz,
    input  logic                 i_last_vertex,
    output logic                 o_face_valid,
    output pfav_pkg::t_face      o_face,
    input  logic                 i_face_full
);
    import pfav_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]       r_state;
    logic [1:0]       r_dim;
    t_coord           r_first [3];
    t_coord           r_prev  [3];
    t_acc             r_cross [3];
    logic [CNT_W-1:0] r_cnt;
    logic             r_clip;
    logic             r_last;
    logic             r_closing;
    logic             r_bad;
    t_coord           r_a [3];
    t_coord           r_b [3];
    t_prod            r_prod [6];

    t_coord               v [3];
    logic signed [IN_W:0] d [3];
    t_acc                 n_cross [3];
    logic                 n_clip;
    logic                 accept;

    assign v[0] = coord_of(i_vx);
    assign v[1] = coord_of(i_vy);
    assign v[2] = coord_of(i_vz);

    assign accept       = push && !full;
    assign full         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_face_valid = (r_state == S_EMIT);

    // First edge difference for edge normals
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = (IN_W+1)'(v[i]) - (IN_W+1)'(r_first[i]);
        end
    end

    // Saturating add of the registered cross terms
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] lim_hi;
        logic signed [SUM_W-1:0] lim_lo;
        lim_hi = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
        lim_lo = -lim_hi - SUM_W'(1);
        n_clip = r_clip;
        for (int i = 0; i < 3; i++) begin
            s = SUM_W'(r_cross[i]) + SUM_W'(r_prod[2*i]) - SUM_W'(r_prod[2*i+1]);
            if (s > lim_hi) begin
                n_cross[i] = ACC_W'(lim_hi);
                n_clip     = 1'b1;
            end else if (s < lim_lo) begin
                n_cross[i] = ACC_W'(lim_lo);
                n_clip     = 1'b1;
            end else begin
                n_cross[i] = ACC_W'(s);
            end
        end
    end

    // Shape the finished face for the back end
    always_comb begin
        o_face = '0;
        if (r_bad) begin
            o_face.bad_dim = 1'b1;
        end else if (r_dim == DIM_3D) begin
            o_face.area_x = r_cross[0];
            o_face.area_y = r_cross[1];
            o_face.area_z = r_cross[2];
            o_face.norm_z = r_cross[2];
            o_face.sat    = r_clip;
        end else begin
            o_face.area_x = -r_cross[1];
            o_face.area_y = r_cross[0];
            o_face.area_z = '0;
            o_face.norm_z = r_cross[2];
            o_face.sat    = r_clip;
        end
    end

    // Products of one edge: (a x b) terms in pairs
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod[0] <= r_a[1] * r_b[2];
            r_prod[1] <= r_a[2] * r_b[1];
            r_prod[2] <= r_a[2] * r_b[0];
            r_prod[3] <= r_a[0] * r_b[2];
            r_prod[4] <= r_a[0] * r_b[1];
            r_prod[5] <= r_a[1] * r_b[0];
        end
    end

    // Sequence one vertex through accumulation and face close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dim     <= DIM_RESET;
            r_cnt     <= '0;
            r_clip    <= 1'b0;
            r_last    <= 1'b0;
            r_closing <= 1'b0;
            r_bad     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_prev[i]  <= '0;
                r_cross[i] <= '0;
                r_a[i]     <= '0;
                r_b[i]     <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_dim <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last_vertex;
                        if (r_dim < DIM_2D) begin
                            if (i_last_vertex) begin
                                r_bad   <= 1'b1;
                                r_state <= S_EMIT;
                            end
                        end else if (r_cnt < CNT_W'(MAX_VERTICES)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            for (int i = 0; i < 3; i++) begin
                                r_prev[i] <= v[i];
                            end
                            if (r_cnt == '0) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_first[i] <= v[i];
                                end
                                if (i_last_vertex) begin
                                    r_state <= (r_dim == DIM_3D) ? S_CLOSE : S_EMIT;
                                end
                            end else if (r_dim == DIM_3D) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_a[i] <= v[i];
                                    r_b[i] <= r_prev[i];
                                end
                                r_closing <= 1'b0;
                                r_state   <= S_MUL;
                            end else begin
                                if (r_cnt == CNT_W'(1)) begin
                                    for (int i = 0; i < 3; i++) begin
                                        r_cross[i] <= {{(ACC_W-IN_W-1-EDGE_SHIFT){d[i][IN_W]}},
                                                       d[i], {EDGE_SHIFT{1'b0}}};
                                    end
                                end
                                if (i_last_vertex) begin
                                    r_state <= S_EMIT;
                                end
                            end
                        end else begin
                            r_clip <= 1'b1;
                            if (i_last_vertex) begin
                                r_state <= (r_dim == DIM_3D) ? S_CLOSE : S_EMIT;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_cross[i] <= n_cross[i];
                    end
                    r_clip <= n_clip;
                    if (r_closing) begin
                        r_state <= S_EMIT;
                    end else if (r_last) begin
                        r_state <= S_CLOSE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLOSE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= r_first[i];
                        r_b[i] <= r_prev[i];
                    end
                    r_closing <= 1'b1;
                    r_state   <= S_MUL;
                end
                S_EMIT: begin
                    if (!i_face_full) begin
                        for (int i = 0; i < 3; i++) begin
                            r_first[i] <= '0;
                            r_prev[i]  <= '0;
                            r_cross[i] <= '0;
                        end
                        r_cnt     <= '0;
                        r_clip    <= 1'b0;
                        r_bad     <= 1'b0;
                        r_closing <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/pfav_fifo.sv =====
// Two-entry queue of finished faces between the front and the back.
module pfav_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pfav_pkg::t_face i_data,
    output logic            o_full,
    input  logic            i_pop,
    output pfav_pkg::t_face o_data,
    output logic            o_empty
);
    import pfav_pkg::*;

    t_face      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== sv/pfav_back.sv =====
// Back end: sum of squares over a shared multiplier, bit-serial square root.
module pfav_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_face_empty,
    input  pfav_pkg::t_face i_face,
    output logic            o_face_pop,
    output logic            empty,
    input  logic            pop,
    output logic [55:0]     o_area_x,
    output logic [55:0]     o_area_y,
    output logic [55:0]     o_area_z,
    output logic [55:0]     o_area_norm,
    output logic            o_bad_dimension,
    output logic            o_saturated
);
    import pfav_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SQ   = 2'd1;
    localparam logic [1:0] B_ROOT = 2'd2;
    localparam logic [1:0] B_HOLD = 2'd3;

    localparam logic [1:0] P_LL = 2'd0;
    localparam logic [1:0] P_LH = 2'd1;
    localparam logic [1:0] P_HH = 2'd2;

    localparam int ROOT_STEPS = ACC_W;

    logic [1:0]          r_state;
    t_face               r_face;
    logic [ACC_W-1:0]    r_mag [3];
    logic [1:0]          r_comp;
    logic [1:0]          r_part;
    logic [3:0]          r_step;
    logic [ACC_W-1:0]    r_prod;
    logic [1:0]          r_pcode;
    logic [SQ_W-1:0]     r_sq;
    logic [REM_W-1:0]    r_rem;
    logic [ACC_W-1:0]    r_root;
    logic [5:0]          r_rcnt;
    logic                r_ovalid;

    logic [ACC_W-1:0]    mag_sel;
    logic [HALF_W-1:0]   op_l;
    logic [HALF_W-1:0]   op_r;
    logic [SQ_W-1:0]     addend;
    logic [REM_W+1:0]    rem2;
    logic [REM_W+1:0]    trial;
    logic                out_free;

    assign o_face_pop = (r_state == B_IDLE) && !i_face_empty;
    assign empty      = !r_ovalid;
    assign out_free   = !r_ovalid || pop;

    // Magnitude of a signed component
    function automatic logic [ACC_W-1:0] mag_of(input t_acc a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

    // Select operand halves for the current partial product
    always_comb begin
        mag_sel = r_mag[r_comp];
        case (r_part)
            P_LL: begin
                op_l = mag_sel[HALF_W-1:0];
                op_r = mag_sel[HALF_W-1:0];
            end
            P_LH: begin
                op_l = mag_sel[HALF_W-1:0];
                op_r = mag_sel[ACC_W-1:HALF_W];
            end
            default: begin
                op_l = mag_sel[ACC_W-1:HALF_W];
                op_r = mag_sel[ACC_W-1:HALF_W];
            end
        endcase
    end

    // Align the registered partial product
    always_comb begin
        case (r_pcode)
            P_LL:    addend = SQ_W'(r_prod);
            P_LH:    addend = SQ_W'(r_prod) << (HALF_W + 1);
            default: addend = SQ_W'(r_prod) << ACC_W;
        endcase
    end

    // One root digit
    assign rem2  = {r_rem, r_sq[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, r_root, 2'b01};

    // Sequence one face through squares, root and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_comp   <= '0;
            r_part   <= '0;
            r_step   <= '0;
            r_rcnt   <= '0;
        end else begin
            // Drop the output transaction once taken, unless a new one replaces it
            if (pop && r_ovalid && !((r_state == B_HOLD) && out_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_face_empty) begin
                        r_face   <= i_face;
                        r_mag[0] <= mag_of(i_face.area_x);
                        r_mag[1] <= mag_of(i_face.area_y);
                        r_mag[2] <= mag_of(i_face.norm_z);
                        r_comp   <= '0;
                        r_part   <= P_LL;
                        r_step   <= '0;
                        r_sq     <= '0;
                        r_state  <= B_SQ;
                    end
                end
                B_SQ: begin
                    if (r_step != 4'd9) begin
                        r_prod  <= ACC_W'(op_l) * ACC_W'(op_r);
                        r_pcode <= r_part;
                        if (r_part == P_HH) begin
                            r_part <= P_LL;
                            r_comp <= r_comp + 2'd1;
                        end else begin
                            r_part <= r_part + 2'd1;
                        end
                    end
                    if (r_step != 4'd0) begin
                        r_sq <= r_sq + addend;
                    end
                    if (r_step == 4'd9) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_rcnt  <= '0;
                        r_state <= B_ROOT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                B_ROOT: begin
                    if (rem2 >= trial) begin
                        r_rem  <= REM_W'(rem2 - trial);
                        r_root <= {r_root[ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= REM_W'(rem2);
                        r_root <= {r_root[ACC_W-2:0], 1'b0};
                    end
                    r_sq <= r_sq << 2;
                    if (r_rcnt == 6'(ROOT_STEPS - 1)) begin
                        r_state <= B_HOLD;
                    end else begin
                        r_rcnt <= r_rcnt + 6'd1;
                    end
                end
                B_HOLD: begin
                    if (out_free) begin
                        o_area_x        <= r_face.area_x;
                        o_area_y        <= r_face.area_y;
                        o_area_z        <= r_face.area_z;
                        o_area_norm     <= r_root;
                        o_bad_dimension <= r_face.bad_dim;
                        o_saturated     <= r_face.sat;
                        r_ovalid        <= 1'b1;
                        r_state         <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/polygon_face_area_vector.sv =====
// Top level of the polygon face area vector block.
//
//  channel   | handshake               | carries
//  ----------+-------------------------+------------------------------------------
//  vertices  | push / full             | i_vx, i_vy, i_vz, i_last_vertex
//  results   | pop / empty             | o_area_x/y/z, o_area_norm, o_bad_dimension,
//            |                         | o_saturated
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_data (dimension)
//
// A vertex that only records state needs no further steps; in 3D mode a later
// vertex passes through edge products, then a saturating add. A closing vertex
// in 3D also runs the closing edge through the same steps, and every face is
// then handed over to the queue. The back end builds the sum of squares through
// one 28x28 multiplier and then takes the bit-serial square root.
// Reset is synchronous and leaves dimension at 3D. A two-face queue lets the
// front keep taking vertices while the back is busy or the output is stalled.
module polygon_face_area_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_vx,
    input  logic [23:0] i_vy,
    input  logic [23:0] i_vz,
    input  logic        i_last_vertex,
    output logic        empty,
    input  logic        pop,
    output logic [55:0] o_area_x,
    output logic [55:0] o_area_y,
    output logic [55:0] o_area_z,
    output logic [55:0] o_area_norm,
    output logic        o_bad_dimension,
    output logic        o_saturated
);
    import pfav_pkg::*;

    logic  face_valid;
    t_face face_in;
    logic  q_full;
    logic  q_pop;
    t_face face_out;
    logic  q_empty;

    // Accumulate vertices
    pfav_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_vx          (i_vx),
        .i_vy          (i_vy),
        .i_vz          (i_vz),
        .i_last_vertex (i_last_vertex),
        .o_face_valid  (face_valid),
        .o_face        (face_in),
        .i_face_full   (q_full)
    );

    // Decouple front and back
    pfav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (face_valid),
        .i_data  (face_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (face_out),
        .o_empty (q_empty)
    );

    // Norm and result output
    pfav_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_face_empty    (q_empty),
        .i_face          (face_out),
        .o_face_pop      (q_pop),
        .empty           (empty),
        .pop             (pop),
        .o_area_x        (o_area_x),
        .o_area_y        (o_area_y),
        .o_area_z        (o_area_z),
        .o_area_norm     (o_area_norm),
        .o_bad_dimension (o_bad_dimension),
        .o_saturated     (o_saturated)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the polygon face area vector block.
`timescale 1ns / 100ps

module testbench;
    import pfav_pkg::*;

    // Stimulus table row kinds
    typedef enum logic {ROW_VERTEX, ROW_DIM} t_row_kind;

    typedef struct {
        logic [55:0] ax;
        logic [55:0] ay;
        logic [55:0] az;
        logic [55:0] norm;
        logic        bad;
        logic        sat;
    } t_area;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  dim;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic        last;
        bit          typed;
        t_area       want;
    } t_row;

    localparam logic [23:0] C_MAX  = 24'h7FFFFF;
    localparam logic [23:0] C_MIN  = 24'h800000;
    localparam logic [1:0]  DIM_0  = 2'd0;
    localparam logic [1:0]  DIM_1  = 2'd1;
    localparam longint      SAT_HI = (64'sd1 <<< 55) - 1;
    localparam longint      SAT_LO = -(64'sd1 <<< 55);
    localparam int          SETTLE = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [23:0] i_vx = '0;
    logic [23:0] i_vy = '0;
    logic [23:0] i_vz = '0;
    logic        i_last_vertex = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [55:0] o_area_x;
    logic [55:0] o_area_y;
    logic [55:0] o_area_z;
    logic [55:0] o_area_norm;
    logic        o_bad_dimension;
    logic        o_saturated;

    polygon_face_area_vector dut (.*);

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state
    logic [1:0] dim_reg;
    longint     face_first [3];
    longint     face_prev [3];
    longint     cross_acc [3];
    int         face_count;
    bit         clip_seen;

    t_area      pending_areas [$];
    t_row       rows [$];
    int         mismatches = 0;
    int         faces_done = 0;
    int         vertices_sent = 0;
    bit         quiet_rx = 1'b0;
    bit         quiet_tx = 1'b0;

    function automatic longint acc_add(longint a, longint t);
        longint s;
        s = a + t;
        if (s > SAT_HI) begin
            clip_seen = 1'b1;
            return SAT_HI;
        end
        if (s < SAT_LO) begin
            clip_seen = 1'b1;
            return SAT_LO;
        end
        return s;
    endfunction

    function automatic logic [55:0] floor_root(longint a, longint b, longint c);
        logic [127:0] sq, t2;
        logic [63:0]  r, t;
        longint       m [3];
        sq = '0;
        r = '0;
        m[0] = a < 0 ? -a : a;
        m[1] = b < 0 ? -b : b;
        m[2] = c < 0 ? -c : c;
        for (int i = 0; i < 3; i++)
            sq += 128'(m[i]) * 128'(m[i]);
        for (int bit_i = 57; bit_i >= 0; bit_i--) begin
            t = r | (64'd1 << bit_i);
            t2 = 128'(t) * 128'(t);
            if (t2 <= sq)
                r = t;
        end
        return r[55:0];
    endfunction

    function automatic void clear_face();
        for (int i = 0; i < 3; i++) begin
            face_first[i] = 0;
            face_prev[i] = 0;
            cross_acc[i] = 0;
        end
        face_count = 0;
        clip_seen = 1'b0;
    endfunction

    // Advance the predictor by one vertex; return 1 when a face closes
    function automatic bit face_step(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                     logic last, output t_area res);
        longint v [3];
        longint f [3];
        longint p [3];
        v[0] = longint'($signed(x));
        v[1] = longint'($signed(y));
        v[2] = longint'($signed(z));
        res = '{default: '0};
        if (dim_reg >= DIM_2D) begin
            if (face_count < MAX_VERTICES) begin
                if (face_count == 0) begin
                    face_first = v;
                end else if (dim_reg == DIM_3D) begin
                    p = face_prev;
                    cross_acc[0] = acc_add(cross_acc[0], v[1] * p[2] - v[2] * p[1]);
                    cross_acc[1] = acc_add(cross_acc[1], v[2] * p[0] - v[0] * p[2]);
                    cross_acc[2] = acc_add(cross_acc[2], v[0] * p[1] - v[1] * p[0]);
                end else if (face_count == 1) begin
                    for (int i = 0; i < 3; i++)
                        cross_acc[i] = (v[i] - face_first[i]) * 8192;
                end
                face_prev = v;
                face_count++;
            end else begin
                clip_seen = 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        if (dim_reg < DIM_2D) begin
            res.bad = 1'b1;
        end else begin
            if (dim_reg == DIM_3D) begin
                f = face_first;
                p = face_prev;
                cross_acc[0] = acc_add(cross_acc[0], f[1] * p[2] - f[2] * p[1]);
                cross_acc[1] = acc_add(cross_acc[1], f[2] * p[0] - f[0] * p[2]);
                cross_acc[2] = acc_add(cross_acc[2], f[0] * p[1] - f[1] * p[0]);
                res.ax = cross_acc[0][55:0];
                res.ay = cross_acc[1][55:0];
                res.az = cross_acc[2][55:0];
            end else begin
                res.ax = 56'(-cross_acc[1]);
                res.ay = cross_acc[0][55:0];
            end
            res.norm = floor_root(cross_acc[0], cross_acc[1], cross_acc[2]);
            res.sat = clip_seen;
        end
        clear_face();
        return 1'b1;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return C_MAX;
            1: return C_MIN;
            2: return 24'($urandom_range(0, 8)) - 24'd4;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic idle_tx();
        int w;
        w = quiet_tx ? 0 : $urandom_range(0, 19);
        if (w > 0) begin
            push <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
    endtask

    // Hand one vertex to the block and record what it should produce
    task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                               logic last, bit typed, t_area want);
        t_area res;
        idle_tx();
        push <= 1'b1;
        i_vx <= x;
        i_vy <= y;
        i_vz <= z;
        i_last_vertex <= last;
        do @(posedge i_clk); while (full);
        vertices_sent++;
        if (face_step(x, y, z, last, res))
            pending_areas.push_back(typed ? want : res);
    endtask

    // Let the block drain and settle, then write the dimension register
    task automatic write_dim(logic [1:0] d);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_areas.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dim_reg = d;
    endtask

    function automatic void add_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                       logic last);
        rows.push_back('{ROW_VERTEX, DIM_0, x, y, z, last, 1'b0, '{default: '0}});
    endfunction

    function automatic void add_checked(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                        t_area want);
        rows.push_back('{ROW_VERTEX, DIM_0, x, y, z, 1'b1, 1'b1, want});
    endfunction

    function automatic void add_dim(logic [1:0] d);
        rows.push_back('{ROW_DIM, d, '0, '0, '0, 1'b0, 1'b0, '{default: '0}});
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_area want;
        if (i_rst_n && pop && !empty) begin
            if (pending_areas.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%h y=%h z=%h", o_area_x, o_area_y, o_area_z);
            end else begin
                want = pending_areas.pop_front();
                faces_done++;
                if (o_area_x !== want.ax || o_area_y !== want.ay || o_area_z !== want.az ||
                    o_area_norm !== want.norm || o_bad_dimension !== want.bad ||
                    o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("face %0d expected x=%h y=%h z=%h n=%h bad=%b sat=%b",
                                 faces_done, want.ax, want.ay, want.az, want.norm,
                                 want.bad, want.sat);
                        $display("face %0d actual   x=%h y=%h z=%h n=%h bad=%b sat=%b",
                                 faces_done, o_area_x, o_area_y, o_area_z, o_area_norm,
                                 o_bad_dimension, o_saturated);
                    end
                end
            end
        end
    end

    // Result side: stall for a random number of cycles before each pop
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            w = quiet_rx ? 0 : $urandom_range(0, 19);
            if (w > 0) begin
                pop <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Hold-off limit
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Main sequence
    initial begin
        int          items;
        int          len;
        logic [1:0]  phase_dim;
        logic [1:0]  dims [10];
        dims = '{DIM_3D, DIM_2D, DIM_0, DIM_3D, DIM_1,
                 DIM_2D, DIM_3D, DIM_2D, DIM_3D, DIM_0};
        dim_reg = DIM_RESET;
        clear_face();

        // Directed table: extremes, each mode and each special case
        add_checked(C_MAX, C_MAX, C_MAX, '{default: '0});
        add_checked(C_MIN, C_MIN, C_MIN, '{default: '0});
        add_vertex(24'd0, 24'd0, 24'd0, 1'b0);
        add_vertex(24'd4096, 24'd0, 24'd0, 1'b0);
        add_checked(24'd0, 24'd4096, 24'd0,
                    '{56'd0, 56'd0, 56'hFF_FFFF_FF00_0000, 56'd16777216, 1'b0, 1'b0});
        add_vertex(C_MIN, C_MIN, 24'd0, 1'b0);
        add_vertex(C_MAX, C_MIN, 24'd0, 1'b0);
        add_vertex(C_MAX, C_MAX, 24'd0, 1'b0);
        add_vertex(C_MIN, C_MAX, 24'd0, 1'b1);
        add_vertex(C_MAX, C_MIN, C_MAX, 1'b0);
        add_vertex(C_MIN, C_MAX, C_MAX, 1'b0);
        add_vertex(C_MIN, C_MIN, C_MAX, 1'b1);
        add_dim(DIM_2D);
        add_vertex(24'd0, 24'd0, 24'd0, 1'b0);
        add_checked(24'd1, 24'd0, 24'd0, '{56'd0, 56'd8192, 56'd0, 56'd8192, 1'b0, 1'b0});
        add_checked(C_MAX, 24'd5, C_MIN, '{default: '0});
        add_vertex(C_MIN, C_MAX, C_MIN, 1'b0);
        add_vertex(C_MAX, C_MIN, C_MAX, 1'b0);
        add_vertex(24'd0, 24'd0, 24'd0, 1'b1);
        add_dim(DIM_1);
        add_checked(C_MAX, C_MIN, C_MAX, '{56'd0, 56'd0, 56'd0, 56'd0, 1'b1, 1'b0});
        add_dim(DIM_0);
        add_vertex(24'd3, 24'd3, 24'd3, 1'b0);
        add_checked(C_MIN, C_MAX, C_MIN, '{56'd0, 56'd0, 56'd0, 56'd0, 1'b1, 1'b0});
        // Dimension changed inside a face
        add_dim(DIM_3D);
        add_vertex(24'd1, 24'd2, 24'd3, 1'b0);
        add_dim(DIM_2D);
        add_vertex(24'd5, 24'd7, 24'd11, 1'b1);

        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_DIM)
                write_dim(rows[r].dim);
            else
                send_vertex(rows[r].x, rows[r].y, rows[r].z, rows[r].last,
                            rows[r].typed, rows[r].want);
        end

        // Random phases: short faces with random content, plus one overlong face in each 2D or 3D phase
        foreach (dims[ph]) begin
            phase_dim = dims[ph];
            write_dim(phase_dim);
            quiet_tx = (ph % 3 == 1);
            quiet_rx = (ph % 4 == 2);
            items = 0;
            if (phase_dim >= DIM_2D) begin
                len = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
                for (int k = 0; k < len; k++)
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1,
                                1'b0, '{default: '0});
                items += len;
            end
            while (items < 100) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                   : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1,
                                1'b0, '{default: '0});
                items += len;
            end
        end

        push <= 1'b0;
        while (pending_areas.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("vertices sent: %0d, faces checked: %0d, mismatches: %0d",
                 vertices_sent, faces_done, mismatches);
        $display("covered 2D, 3D and unsupported modes, overlong faces, extreme coordinates");
        if (mismatches == 0 && pending_areas.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
